### sv/vcc_pkg.sv
package vcc_pkg;

    localparam int DATA_W  = 16;
    localparam int SIZE_W  = 10;
    localparam int COORD_W = 9;
    localparam int EDGE_W  = 12;
    localparam int CNT_W   = 27;
    localparam int CIDX_W  = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ISO    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_DEPTH  = 2'd3;

    // crossed edges a cell owns, by boundary case
    localparam logic [EDGE_W-1:0] OWN_BASE = 12'h109;
    localparam logic [EDGE_W-1:0] OWN_X    = 12'h804;
    localparam logic [EDGE_W-1:0] OWN_Y    = 12'h202;
    localparam logic [EDGE_W-1:0] OWN_Z    = 12'h090;
    localparam logic [EDGE_W-1:0] OWN_XY   = 12'h400;
    localparam logic [EDGE_W-1:0] OWN_XZ   = 12'h040;
    localparam logic [EDGE_W-1:0] OWN_YZ   = 12'h020;

    // quad emission codes
    localparam logic [1:0] QUAD_NONE   = 2'd0;
    localparam logic [1:0] QUAD_FAR    = 2'd1;
    localparam logic [1:0] QUAD_ORIGIN = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic               emit;
        logic               done;
        logic               last_x;
        logic               last_y;
        logic               last_z;
        logic               allow_y;
        logic               allow_z;
        logic               allow_x;
    } t_cell_info;

    typedef struct packed {
        logic [7:0] corner;
        t_cell_info info;
    } t_s1;

    // edge e is set when its two corners differ
    function automatic logic [EDGE_W-1:0] edges_of(input logic [7:0] c);
        return {c[3] ^ c[7], c[2] ^ c[6], c[1] ^ c[5], c[0] ^ c[4],
                c[7] ^ c[4], c[6] ^ c[7], c[5] ^ c[6], c[4] ^ c[5],
                c[3] ^ c[0], c[2] ^ c[3], c[1] ^ c[2], c[0] ^ c[1]};
    endfunction

    function automatic logic [1:0] quad_code(input logic c0, input logic cf,
                                             input logic allow);
        logic [1:0] q;
        q = QUAD_NONE;
        if (allow && (c0 != cf)) begin
            q = cf ? QUAD_FAR : QUAD_ORIGIN;
        end
        return q;
    endfunction

endpackage

### sv/vcc_cfg.sv
module vcc_cfg #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_DEPTH  = 512,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int DW = $clog2(MAX_DEPTH + 1),
    localparam int LD = MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1,
    localparam int AW = $clog2(LD)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [vcc_pkg::CIDX_W-1:0]          i_index,
    input  logic [vcc_pkg::DATA_W-1:0]          i_data,
    output logic signed [vcc_pkg::DATA_W-1:0]   o_iso,
    output logic [WW-1:0]                       o_w,
    output logic [HW-1:0]                       o_h,
    output logic [DW-1:0]                       o_d,
    output logic [AW-1:0]                       o_sl,
    output logic [AW-1:0]                       o_slw
);

    localparam int RST_W  = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
    localparam int RST_H  = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;
    localparam int RST_D  = (MAX_DEPTH < 512) ? MAX_DEPTH : 512;
    localparam int RST_SL = RST_W * RST_H;

    logic signed [vcc_pkg::DATA_W-1:0] r_iso, n_iso;
    logic [WW-1:0] r_w, n_w;
    logic [HW-1:0] r_h, n_h;
    logic [DW-1:0] r_d, n_d;
    logic [AW-1:0] r_sl, n_sl;
    logic [AW-1:0] r_slw, n_slw;

    function automatic logic [12:0] clamp_size(input logic [vcc_pkg::SIZE_W-1:0] v,
                                               input int hi);
        logic [12:0] r;
        r = 13'(v);
        if (v < 10'd3) begin
            r = 13'd3;
        end else if (int'(v) > hi) begin
            r = 13'(hi);
        end
        return r;
    endfunction

    always_comb begin
        n_iso = r_iso;
        n_w   = r_w;
        n_h   = r_h;
        n_d   = r_d;
        case (i_index)
            vcc_pkg::CFG_ISO:    n_iso = $signed(i_data);
            vcc_pkg::CFG_WIDTH:  n_w = WW'(clamp_size(i_data[vcc_pkg::SIZE_W-1:0], MAX_WIDTH));
            vcc_pkg::CFG_HEIGHT: n_h = HW'(clamp_size(i_data[vcc_pkg::SIZE_W-1:0], MAX_HEIGHT));
            vcc_pkg::CFG_DEPTH:  n_d = DW'(clamp_size(i_data[vcc_pkg::SIZE_W-1:0], MAX_DEPTH));
            default: ;
        endcase
        // slice size and slice plus line, held ready for the tap addresses
        n_sl  = AW'(n_w) * AW'(n_h);
        n_slw = n_sl + AW'(n_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= '0;
            r_w   <= WW'(RST_W);
            r_h   <= HW'(RST_H);
            r_d   <= DW'(RST_D);
            r_sl  <= AW'(RST_SL);
            r_slw <= AW'(RST_SL + RST_W);
        end else if (i_we) begin
            r_iso <= n_iso;
            r_w   <= n_w;
            r_h   <= n_h;
            r_d   <= n_d;
            r_sl  <= n_sl;
            r_slw <= n_slw;
        end
    end

    assign o_iso = r_iso;
    assign o_w   = r_w;
    assign o_h   = r_h;
    assign o_d   = r_d;
    assign o_sl  = r_sl;
    assign o_slw = r_slw;

endmodule

### sv/vcc_front.sv
module vcc_front #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_DEPTH  = 512,
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int HW  = $clog2(MAX_HEIGHT + 1),
    localparam int DW  = $clog2(MAX_DEPTH + 1),
    localparam int LD  = MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1,
    localparam int AW  = $clog2(LD)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [vcc_pkg::DATA_W-1:0] i_sample,
    input  logic signed [vcc_pkg::DATA_W-1:0] i_iso,
    input  logic [WW-1:0]                     i_w,
    input  logic [HW-1:0]                     i_h,
    input  logic [DW-1:0]                     i_d,
    input  logic [AW-1:0]                     i_sl,
    input  logic [AW-1:0]                     i_slw,
    output logic                              o_s1_valid,
    output vcc_pkg::t_s1                      o_s1,
    input  logic                              i_s1_ready
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int ZW  = $clog2(MAX_DEPTH);
    localparam int LAW = $clog2(MAX_WIDTH);
    localparam int LAX = $clog2(2 * MAX_WIDTH);
    localparam int AWX = $clog2(2 * LD);

    // flag pairs {previous, current}: line buffer and full slice buffer
    logic [1:0] line_mem [MAX_WIDTH];
    logic [1:0] slice_mem [LD];

    logic [XW-1:0]  r_px, n_px;
    logic [YW-1:0]  r_py, n_py;
    logic [ZW-1:0]  r_pz, n_pz;
    logic [LAW-1:0] r_lp;
    logic [AW-1:0]  r_sp;
    logic           r_last_f;
    logic           r_s1_valid;
    vcc_pkg::t_cell_info r_info, n_info;
    logic           r_s1_f;
    logic           r_s1_tap1;
    logic [1:0]     r_rd_w;
    logic [1:0]     r_rd_sl;
    logic [1:0]     r_rd_slw;

    logic           accept;
    logic           flag;
    logic [WW-1:0]  w_m1;
    logic [HW-1:0]  h_m1;
    logic [DW-1:0]  d_m1;
    logic [WW-1:0]  px_e;
    logic [HW-1:0]  py_e;
    logic [DW-1:0]  pz_e;
    logic           x_in, y_in, z_in;
    logic [LAX-1:0] lp_e, w_e;
    logic [LAW-1:0] line_rd;
    logic [AWX-1:0] sp_e, sl_e, slw_e;
    logic [AW-1:0]  sl_rd, slw_rd;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_s1_valid || i_s1_ready;
    assign flag    = i_sample < i_iso;

    assign w_m1 = i_w - WW'(1);
    assign h_m1 = i_h - HW'(1);
    assign d_m1 = i_d - DW'(1);
    assign px_e = WW'(r_px);
    assign py_e = HW'(r_py);
    assign pz_e = DW'(r_pz);

    assign x_in = (r_px >= XW'(2)) && (px_e <= w_m1);
    assign y_in = (r_py >= YW'(2)) && (py_e <= h_m1);
    assign z_in = (r_pz >= ZW'(2)) && (pz_e <= d_m1);

    // read addresses w, slice and slice plus line samples back
    assign lp_e    = LAX'(r_lp);
    assign w_e     = LAX'(i_w);
    assign line_rd = (lp_e >= w_e) ? LAW'(lp_e - w_e)
                                   : LAW'(lp_e + LAX'(MAX_WIDTH) - w_e);
    assign sp_e    = AWX'(r_sp);
    assign sl_e    = AWX'(i_sl);
    assign slw_e   = AWX'(i_slw);
    assign sl_rd   = (sp_e >= sl_e) ? AW'(sp_e - sl_e) : AW'(sp_e + AWX'(LD) - sl_e);
    assign slw_rd  = (sp_e >= slw_e) ? AW'(sp_e - slw_e) : AW'(sp_e + AWX'(LD) - slw_e);

    always_comb begin
        n_px = r_px + XW'(1);
        n_py = r_py;
        n_pz = r_pz;
        if (px_e >= w_m1) begin
            n_px = '0;
            if (py_e >= h_m1) begin
                n_py = '0;
                n_pz = (pz_e >= d_m1) ? '0 : r_pz + ZW'(1);
            end else begin
                n_py = r_py + YW'(1);
            end
        end

        n_info.cell_x  = vcc_pkg::COORD_W'(r_px - XW'(1));
        n_info.cell_y  = vcc_pkg::COORD_W'(r_py - YW'(1));
        n_info.cell_z  = vcc_pkg::COORD_W'(r_pz - ZW'(1));
        n_info.emit    = x_in && y_in && z_in;
        n_info.last_x  = px_e == w_m1;
        n_info.last_y  = py_e == h_m1;
        n_info.last_z  = pz_e == d_m1;
        n_info.done    = n_info.emit && n_info.last_x && n_info.last_y && n_info.last_z;
        n_info.allow_y = (r_px > XW'(2)) && (r_pz > ZW'(2));
        n_info.allow_z = (r_px > XW'(2)) && (r_py > YW'(2));
        n_info.allow_x = (r_py > YW'(2)) && (r_pz > ZW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px       <= '0;
            r_py       <= '0;
            r_pz       <= '0;
            r_lp       <= '0;
            r_sp       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_px <= n_px;
                r_py <= n_py;
                r_pz <= n_pz;
                r_lp <= (r_lp == LAW'(MAX_WIDTH - 1)) ? '0 : r_lp + LAW'(1);
                r_sp <= (r_sp == AW'(LD - 1)) ? '0 : r_sp + AW'(1);
                r_s1_valid <= 1'b1;
            end else if (i_s1_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // push the new flag pair, read the older taps; reads see pre-write contents
    always_ff @(posedge i_clk) begin
        if (accept) begin
            line_mem[r_lp]  <= {r_last_f, flag};
            slice_mem[r_sp] <= {r_last_f, flag};
            r_rd_w          <= line_mem[line_rd];
            r_rd_sl         <= slice_mem[sl_rd];
            r_rd_slw        <= slice_mem[slw_rd];
            r_last_f        <= flag;
            r_s1_f          <= flag;
            r_s1_tap1       <= r_last_f;
            r_info          <= n_info;
        end
    end

    assign o_s1_valid  = r_s1_valid;
    assign o_s1.info   = r_info;
    assign o_s1.corner = {r_rd_w[0], r_s1_f, r_s1_tap1, r_rd_w[1],
                          r_rd_slw[0], r_rd_sl[0], r_rd_sl[1], r_rd_slw[1]};

endmodule

### sv/vcc_classify.sv
module vcc_classify (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s1_valid,
    input  vcc_pkg::t_s1                      i_s1,
    output logic                              o_s1_ready,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [vcc_pkg::COORD_W-1:0]       o_cell_x,
    output logic [vcc_pkg::COORD_W-1:0]       o_cell_y,
    output logic [vcc_pkg::COORD_W-1:0]       o_cell_z,
    output logic [7:0]                        o_corner_mask,
    output logic [vcc_pkg::EDGE_W-1:0]        o_edge_mask,
    output logic [vcc_pkg::EDGE_W-1:0]        o_intersect_mask,
    output logic [1:0]                        o_quad_along_y,
    output logic [1:0]                        o_quad_along_z,
    output logic [1:0]                        o_quad_along_x,
    output logic [vcc_pkg::CNT_W-1:0]         o_cell_number,
    output logic                              o_volume_done
);

    logic [vcc_pkg::EDGE_W-1:0] edges;
    logic [vcc_pkg::EDGE_W-1:0] own;
    logic                       load;

    logic                        r_valid;
    logic [vcc_pkg::CNT_W-1:0]   r_cnt;
    logic [vcc_pkg::COORD_W-1:0] r_cell_x, r_cell_y, r_cell_z;
    logic [7:0]                  r_corner;
    logic [vcc_pkg::EDGE_W-1:0]  r_edges, r_isect;
    logic [1:0]                  r_qy, r_qz, r_qx;
    logic [vcc_pkg::CNT_W-1:0]   r_num;
    logic                        r_done;

    // cells that emit nothing drain without waiting on the output register
    assign o_s1_ready = !i_s1.info.emit || !r_valid || i_ready;
    assign load       = i_s1_valid && o_s1_ready && i_s1.info.emit;

    assign edges = vcc_pkg::edges_of(i_s1.corner);

    always_comb begin
        own = vcc_pkg::OWN_BASE;
        if (i_s1.info.last_x) own = own | vcc_pkg::OWN_X;
        if (i_s1.info.last_y) own = own | vcc_pkg::OWN_Y;
        if (i_s1.info.last_z) own = own | vcc_pkg::OWN_Z;
        if (i_s1.info.last_x && i_s1.info.last_y) own = own | vcc_pkg::OWN_XY;
        if (i_s1.info.last_x && i_s1.info.last_z) own = own | vcc_pkg::OWN_XZ;
        if (i_s1.info.last_y && i_s1.info.last_z) own = own | vcc_pkg::OWN_YZ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                if (i_s1.info.done) begin
                    r_cnt <= '0;
                end else if (edges != '0) begin
                    r_cnt <= r_cnt + vcc_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cell_x <= i_s1.info.cell_x;
            r_cell_y <= i_s1.info.cell_y;
            r_cell_z <= i_s1.info.cell_z;
            r_corner <= i_s1.corner;
            r_edges  <= edges;
            r_isect  <= edges & own;
            r_qy     <= vcc_pkg::quad_code(i_s1.corner[0], i_s1.corner[1], i_s1.info.allow_y);
            r_qz     <= vcc_pkg::quad_code(i_s1.corner[0], i_s1.corner[4], i_s1.info.allow_z);
            r_qx     <= vcc_pkg::quad_code(i_s1.corner[0], i_s1.corner[3], i_s1.info.allow_x);
            r_num    <= r_cnt;
            r_done   <= i_s1.info.done;
        end
    end

    assign o_valid          = r_valid;
    assign o_cell_x         = r_cell_x;
    assign o_cell_y         = r_cell_y;
    assign o_cell_z         = r_cell_z;
    assign o_corner_mask    = r_corner;
    assign o_edge_mask      = r_edges;
    assign o_intersect_mask = r_isect;
    assign o_quad_along_y   = r_qy;
    assign o_quad_along_z   = r_qz;
    assign o_quad_along_x   = r_qx;
    assign o_cell_number    = r_num;
    assign o_volume_done    = r_done;

endmodule

### sv/volume_cell_classifier.sv
// Volume cell classifier: marching-cubes style classification of a voxel stream.
// Input channel (i_valid/o_ready, i_sample): one signed voxel per request, raster
// order, x fastest, then y, then z. Each voxel is flagged inside when it lies
// strictly below iso_level.
// Output channel (o_valid/i_ready): one request per cell whose origin lies from 1
// to size-2 on every axis, carrying origin, corner mask, crossed and owned edge
// masks, three quad codes, the running active-cell number and a volume-done flag.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 iso_level,
// 1 width, 2 height, 3 depth; sizes are clamped to [3, MAX_*] when written.
// Throughput: one voxel per cycle while o_ready stays high; output stalls can drop it.
// An accepted voxel's cell reaches the output in two steps: the accepting edge loads the flag
// buffer reads (line buffer of MAX_WIDTH pairs, slice buffer of MAX_WIDTH*MAX_HEIGHT+MAX_WIDTH+1
// pairs with two read ports) into the middle stage, and the cell is then classified into the
// output register once that register is free to take it.
// Reset clears positions, pointers, the active-cell count and all valid flags;
// the flag buffers are not cleared and fill as the first volume streams in.
// When the receiver stalls, the output register holds its cell, the middle stage
// holds behind it, and o_ready drops once both are full; voxels that close no
// cell keep flowing through the middle stage.
module volume_cell_classifier #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_DEPTH  = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [vcc_pkg::DATA_W-1:0]   i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [vcc_pkg::COORD_W-1:0]         o_cell_x,
    output logic [vcc_pkg::COORD_W-1:0]         o_cell_y,
    output logic [vcc_pkg::COORD_W-1:0]         o_cell_z,
    output logic [7:0]                          o_corner_mask,
    output logic [vcc_pkg::EDGE_W-1:0]          o_edge_mask,
    output logic [vcc_pkg::EDGE_W-1:0]          o_intersect_mask,
    output logic [1:0]                          o_quad_along_y,
    output logic [1:0]                          o_quad_along_z,
    output logic [1:0]                          o_quad_along_x,
    output logic [vcc_pkg::CNT_W-1:0]           o_cell_number,
    output logic                                o_volume_done,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vcc_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [vcc_pkg::DATA_W-1:0]          i_cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int LD = MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1;
    localparam int AW = $clog2(LD);

    logic signed [vcc_pkg::DATA_W-1:0] iso;
    logic [WW-1:0] size_w;
    logic [HW-1:0] size_h;
    logic [DW-1:0] size_d;
    logic [AW-1:0] dist_sl;
    logic [AW-1:0] dist_slw;

    logic          s1_valid;
    logic          s1_ready;
    vcc_pkg::t_s1  s1;

    // configuration writes never stall
    assign o_cfg_ready = 1'b1;

    vcc_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_iso   (iso),
        .o_w     (size_w),
        .o_h     (size_h),
        .o_d     (size_d),
        .o_sl    (dist_sl),
        .o_slw   (dist_slw)
    );

    // flag, position tracking and delay-line taps
    vcc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .i_iso      (iso),
        .i_w        (size_w),
        .i_h        (size_h),
        .i_d        (size_d),
        .i_sl       (dist_sl),
        .i_slw      (dist_slw),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .i_s1_ready (s1_ready)
    );

    // edge masks, ownership, quads, count and output register
    vcc_classify u_classify (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s1_valid       (s1_valid),
        .i_s1             (s1),
        .o_s1_ready       (s1_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_cell_x         (o_cell_x),
        .o_cell_y         (o_cell_y),
        .o_cell_z         (o_cell_z),
        .o_corner_mask    (o_corner_mask),
        .o_edge_mask      (o_edge_mask),
        .o_intersect_mask (o_intersect_mask),
        .o_quad_along_y   (o_quad_along_y),
        .o_quad_along_z   (o_quad_along_z),
        .o_quad_along_x   (o_quad_along_x),
        .o_cell_number    (o_cell_number),
        .o_volume_done    (o_volume_done)
    );

endmodule

### sv/vcc_checker.sv
module vcc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [vcc_pkg::COORD_W-1:0]   o_cell_x,
    input logic [7:0]                    o_corner_mask,
    input logic [vcc_pkg::EDGE_W-1:0]    o_edge_mask,
    input logic [vcc_pkg::EDGE_W-1:0]    o_intersect_mask,
    input logic [1:0]                    o_quad_along_y,
    input logic [vcc_pkg::CNT_W-1:0]     o_cell_number
);

    // a stalled cell holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cell_x) && $stable(o_corner_mask)
            && $stable(o_cell_number))
        else $error("output cell changed while stalled");

    // reset drops the output valid
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // owned edges are always crossed edges
    a_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_intersect_mask & ~o_edge_mask) == '0)
        else $error("intersect mask outside edge mask");

    // a y quad needs corners 0 and 1 to differ, the code following corner 1
    a_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_quad_along_y != vcc_pkg::QUAD_NONE) |->
            (o_corner_mask[0] != o_corner_mask[1]) && o_edge_mask[0] &&
            ((o_quad_along_y == vcc_pkg::QUAD_FAR) == o_corner_mask[1]))
        else $error("quad code inconsistent with corner mask");

endmodule

bind volume_cell_classifier vcc_checker u_vcc_checker (.*);

### verif/volume_cell_classifier_test.sv
module volume_cell_classifier_test;

    localparam int MAX_W = 512;
    localparam int MAX_H = 512;
    localparam int MAX_D = 512;
    // the slice-plus-line-plus-one flag history the block keeps
    localparam int HIST_DEPTH = MAX_W * MAX_H + MAX_W + 1;
    localparam int RANDOM_VOXELS = 950;
    localparam int PRINT_CAP = 40;

    // corner offsets from the cell origin, one bit per corner-mask position
    localparam logic [7:0] CORNER_DX = 8'b1100_1100;
    localparam logic [7:0] CORNER_DY = 8'b0110_0110;
    localparam logic [7:0] CORNER_DZ = 8'b1111_0000;

    typedef struct packed {
        logic [vcc_pkg::COORD_W-1:0] x;
        logic [vcc_pkg::COORD_W-1:0] y;
        logic [vcc_pkg::COORD_W-1:0] z;
        logic [7:0]                  corners;
        logic [vcc_pkg::EDGE_W-1:0]  edges;
        logic [vcc_pkg::EDGE_W-1:0]  owned;
        logic [1:0]                  quad_y;
        logic [1:0]                  quad_z;
        logic [1:0]                  quad_x;
        logic [vcc_pkg::CNT_W-1:0]   number;
        logic                        done;
    } t_cell;

    logic                                i_clk;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic signed [vcc_pkg::DATA_W-1:0]   i_sample = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [vcc_pkg::COORD_W-1:0]         o_cell_x;
    logic [vcc_pkg::COORD_W-1:0]         o_cell_y;
    logic [vcc_pkg::COORD_W-1:0]         o_cell_z;
    logic [7:0]                          o_corner_mask;
    logic [vcc_pkg::EDGE_W-1:0]          o_edge_mask;
    logic [vcc_pkg::EDGE_W-1:0]          o_intersect_mask;
    logic [1:0]                          o_quad_along_y;
    logic [1:0]                          o_quad_along_z;
    logic [1:0]                          o_quad_along_x;
    logic [vcc_pkg::CNT_W-1:0]           o_cell_number;
    logic                                o_volume_done;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [vcc_pkg::CIDX_W-1:0]          i_cfg_index = vcc_pkg::CFG_ISO;
    logic [vcc_pkg::DATA_W-1:0]          i_cfg_data = '0;

    volume_cell_classifier i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_cell_x         (o_cell_x),
        .o_cell_y         (o_cell_y),
        .o_cell_z         (o_cell_z),
        .o_corner_mask    (o_corner_mask),
        .o_edge_mask      (o_edge_mask),
        .o_intersect_mask (o_intersect_mask),
        .o_quad_along_y   (o_quad_along_y),
        .o_quad_along_z   (o_quad_along_z),
        .o_quad_along_x   (o_quad_along_x),
        .o_cell_number    (o_cell_number),
        .o_volume_done    (o_volume_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Classifier state as the testbench sees it
    // ------------------------------------------------------------------
    logic signed [vcc_pkg::DATA_W-1:0] iso_ref;
    int                                width_ref;
    int                                height_ref;
    int                                depth_ref;
    int                                pos_x;
    int                                pos_y;
    int                                pos_z;
    logic [vcc_pkg::CNT_W-1:0]         active_cells;
    bit                                flag_hist [HIST_DEPTH];
    int                                hist_wr;
    int                                voxels_taken;

    logic signed [vcc_pkg::DATA_W-1:0] voxel_queue [$];
    t_cell                             pending_cells [$];
    int                                mismatch_count = 0;
    int                                drv_calm = 0;
    int                                mon_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Give up well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int clamp_size(logic [vcc_pkg::SIZE_W-1:0] v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Advance a raster position; wrap each axis once it reaches or passes its last index.
    function automatic void step_position(inout int x, inout int y, inout int z);
        if (x >= width_ref - 1) begin
            x = 0;
            if (y >= height_ref - 1) begin
                y = 0;
                z = (z >= depth_ref - 1) ? 0 : z + 1;
            end else begin
                y = y + 1;
            end
        end else begin
            x = x + 1;
        end
    endfunction

    function automatic logic [1:0] quad_for(logic origin_in, logic far_in, bit allowed);
        if (!allowed || origin_in == far_in) return vcc_pkg::QUAD_NONE;
        return far_in ? vcc_pkg::QUAD_FAR : vcc_pkg::QUAD_ORIGIN;
    endfunction

    // Push one voxel into the flag history and queue the cell it closes, if any.
    task automatic classify_voxel(input logic signed [vcc_pkg::DATA_W-1:0] v);
        int                         slice;
        int                         cx;
        int                         cy;
        int                         cz;
        int                         back;
        bit                         f;
        bit                         emit;
        bit                         done;
        bit                         lx;
        bit                         ly;
        bit                         lz;
        logic [7:0]                 cm;
        logic [vcc_pkg::EDGE_W-1:0] em;
        logic [vcc_pkg::EDGE_W-1:0] own;
        t_cell                      c;
        slice = width_ref * height_ref;
        emit = pos_x >= 2 && pos_x <= width_ref - 1 && pos_y >= 2 && pos_y <= height_ref - 1 &&
               pos_z >= 2 && pos_z <= depth_ref - 1;
        done = emit && pos_x == width_ref - 1 && pos_y == height_ref - 1 &&
               pos_z == depth_ref - 1;
        f = (v < iso_ref);
        voxels_taken++;
        if (emit) begin
            cx = pos_x - 1;
            cy = pos_y - 1;
            cz = pos_z - 1;
            // the far corner is the voxel itself; the rest come from the history
            for (int b = 0; b < 8; b++) begin
                back = (CORNER_DZ[b] ? 0 : slice) + (CORNER_DY[b] ? 0 : width_ref) +
                       (CORNER_DX[b] ? 0 : 1);
                cm[b] = (back == 0) ? f
                                    : flag_hist[(hist_wr + HIST_DEPTH - back) % HIST_DEPTH];
            end
            // near face ring, far face ring, then the edges joining them
            for (int e = 0; e < 4; e++) begin
                em[e]     = cm[e] ^ cm[(e + 1) % 4];
                em[e + 4] = cm[e + 4] ^ cm[4 + (e + 1) % 4];
                em[e + 8] = cm[e] ^ cm[e + 4];
            end
            c = '0;
            c.x = cx[vcc_pkg::COORD_W-1:0];
            c.y = cy[vcc_pkg::COORD_W-1:0];
            c.z = cz[vcc_pkg::COORD_W-1:0];
            c.corners = cm;
            c.edges = em;
            c.number = active_cells;
            c.done = done;
            if (em != '0) begin
                lx = (cx == width_ref - 2);
                ly = (cy == height_ref - 2);
                lz = (cz == depth_ref - 2);
                own = vcc_pkg::OWN_BASE;
                if (lx) own |= vcc_pkg::OWN_X;
                if (ly) own |= vcc_pkg::OWN_Y;
                if (lz) own |= vcc_pkg::OWN_Z;
                if (lx && ly) own |= vcc_pkg::OWN_XY;
                if (lx && lz) own |= vcc_pkg::OWN_XZ;
                if (ly && lz) own |= vcc_pkg::OWN_YZ;
                c.owned = em & own;
                c.quad_y = quad_for(cm[0], cm[1], cx > 1 && cz > 1);
                c.quad_z = quad_for(cm[0], cm[4], cx > 1 && cy > 1);
                c.quad_x = quad_for(cm[0], cm[3], cy > 1 && cz > 1);
                active_cells = active_cells + vcc_pkg::CNT_W'(1);
            end
            pending_cells.insert(pending_cells.size(), c);
        end
        // store after the taps so the oldest entry still reads a full history back
        flag_hist[hist_wr] = f;
        hist_wr = (hist_wr + 1) % HIST_DEPTH;
        step_position(pos_x, pos_y, pos_z);
        if (done) active_cells = '0;
    endtask

    // Reset the mirrored state; track register writes at the request edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            iso_ref = '0;
            width_ref = MAX_W;
            height_ref = MAX_H;
            depth_ref = MAX_D;
            pos_x = 0;
            pos_y = 0;
            pos_z = 0;
            active_cells = '0;
            hist_wr = 0;
            voxels_taken = 0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                vcc_pkg::CFG_ISO:    iso_ref = i_cfg_data;
                vcc_pkg::CFG_WIDTH:  width_ref = clamp_size(i_cfg_data[vcc_pkg::SIZE_W-1:0],
                                                            MAX_W);
                vcc_pkg::CFG_HEIGHT: height_ref = clamp_size(i_cfg_data[vcc_pkg::SIZE_W-1:0],
                                                             MAX_H);
                vcc_pkg::CFG_DEPTH:  depth_ref = clamp_size(i_cfg_data[vcc_pkg::SIZE_W-1:0],
                                                            MAX_D);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Voxel driver: hold a request until taken, then load the next one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit gap;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) classify_voxel(i_sample);
            if (!i_valid || o_ready) begin
                // drop into a long gapless stretch now and then
                if (drv_calm > 0) begin
                    drv_calm--;
                    gap = 1'b0;
                end else begin
                    if ($urandom_range(499) == 0) drv_calm = 400;
                    gap = ($urandom_range(99) < 28);
                end
                if (voxel_queue.size() != 0 && !gap) begin
                    i_valid <= 1'b1;
                    i_sample <= voxel_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Cell monitor: compare each taken request with the oldest pending cell
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic compare_cell(input t_cell got, input t_cell want);
        string at;
        at = $sformatf("cell (%0d,%0d,%0d)", want.x, want.y, want.z);
        if (got.x != want.x) report_mismatch($sformatf("%s x got %0d", at, got.x));
        if (got.y != want.y) report_mismatch($sformatf("%s y got %0d", at, got.y));
        if (got.z != want.z) report_mismatch($sformatf("%s z got %0d", at, got.z));
        if (got.corners != want.corners)
            report_mismatch($sformatf("%s corners got %h want %h", at, got.corners, want.corners));
        if (got.edges != want.edges)
            report_mismatch($sformatf("%s edges got %h want %h", at, got.edges, want.edges));
        if (got.owned != want.owned)
            report_mismatch($sformatf("%s owned got %h want %h", at, got.owned, want.owned));
        if (got.quad_y != want.quad_y)
            report_mismatch($sformatf("%s quad y got %0d want %0d", at, got.quad_y, want.quad_y));
        if (got.quad_z != want.quad_z)
            report_mismatch($sformatf("%s quad z got %0d want %0d", at, got.quad_z, want.quad_z));
        if (got.quad_x != want.quad_x)
            report_mismatch($sformatf("%s quad x got %0d want %0d", at, got.quad_x, want.quad_x));
        if (got.number != want.number)
            report_mismatch($sformatf("%s number got %0d want %0d", at, got.number, want.number));
        if (got.done != want.done)
            report_mismatch($sformatf("%s done got %0d want %0d", at, got.done, want.done));
    endtask

    always @(posedge i_clk) begin
        t_cell got;
        bit    stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_cell_x, o_cell_y, o_cell_z, o_corner_mask, o_edge_mask,
                        o_intersect_mask, o_quad_along_y, o_quad_along_z, o_quad_along_x,
                        o_cell_number, o_volume_done};
                if (pending_cells.size() == 0)
                    report_mismatch($sformatf("cell (%0d,%0d,%0d) with none pending",
                                              got.x, got.y, got.z));
                else
                    compare_cell(got, pending_cells.pop_front());
            end
            if (mon_calm > 0) begin
                mon_calm--;
                stall = 1'b0;
            end else begin
                if ($urandom_range(499) == 0) mon_calm = 400;
                stall = ($urandom_range(99) < 28);
            end
            i_ready <= !stall;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Issue one register request; call at a rising edge, return at the taking edge.
    task automatic write_reg(input logic [vcc_pkg::CIDX_W-1:0] idx,
                             input logic [vcc_pkg::DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Size words carry junk above the size field; only the low bits count.
    function automatic logic [vcc_pkg::DATA_W-1:0] size_word(
        input logic [vcc_pkg::SIZE_W-1:0] n);
        logic [31:0]                                rnd;
        logic [vcc_pkg::DATA_W-vcc_pkg::SIZE_W-1:0] junk;
        rnd = $urandom;
        junk = rnd[vcc_pkg::DATA_W-vcc_pkg::SIZE_W-1:0];
        return {junk, n};
    endfunction

    task automatic load_config(input logic signed [vcc_pkg::DATA_W-1:0] iso,
                               input int w, input int h, input int d);
        write_reg(vcc_pkg::CFG_ISO, iso);
        write_reg(vcc_pkg::CFG_WIDTH, size_word(w[vcc_pkg::SIZE_W-1:0]));
        write_reg(vcc_pkg::CFG_HEIGHT, size_word(h[vcc_pkg::SIZE_W-1:0]));
        write_reg(vcc_pkg::CFG_DEPTH, size_word(d[vcc_pkg::SIZE_W-1:0]));
        i_cfg_valid <= 1'b0;
        // let the tracked registers settle before reading them
        @(negedge i_clk);
    endtask

    // Wait until every voxel is taken and every cell is back, then let the
    // pipeline flush voxels that close no cell.
    task automatic settle();
        do @(posedge i_clk);
        while (voxel_queue.size() != 0 || i_valid || pending_cells.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Voxels left until the position counters come back to the volume origin.
    function automatic int voxels_to_volume_end();
        int x;
        int y;
        int z;
        int n;
        x = pos_x;
        y = pos_y;
        z = pos_z;
        n = 0;
        do begin
            step_position(x, y, z);
            n++;
        end while (x != 0 || y != 0 || z != 0);
        return n;
    endfunction

    // Mostly values hugging the threshold, so corners split; some full range and rails.
    function automatic logic signed [vcc_pkg::DATA_W-1:0] pick_voxel(input int spread);
        int          r;
        int          v;
        logic [15:0] raw;
        r = $urandom_range(99);
        raw = 16'($urandom);
        if (r < 15) return raw;
        if (r < 20) return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        v = int'(iso_ref) + int'($urandom_range(2 * spread)) - spread;
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[vcc_pkg::DATA_W-1:0];
    endfunction

    task automatic stream(input int n, input int spread);
        for (int i = 0; i < n; i++) voxel_queue.insert(voxel_queue.size(), pick_voxel(spread));
    endtask

    initial begin
        int opening [27];
        int random_sent;
        int w;
        int h;
        int d;
        int n;
        int spread;
        int iso;

        // one 3x3x3 volume; the single cell's corners mix rails, values at and
        // just around the threshold, so the mask is neither empty nor full
        opening = '{7, -3, 32767, -32768, 0, 1, -1, 200, -200,
                    32767, 12, -12, 0, -32768, 32767, 4, 0, -1,
                    -9, 9, 1000, -1000, 1, -1, 32767, -32768, 0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_config(16'sd0, 3, 3, 3);
        foreach (opening[i]) voxel_queue.insert(voxel_queue.size(), 16'(opening[i]));
        settle();

        // size words below the minimum on every axis, clamped up
        load_config(16'sd0, 0, 2, 1);
        stream(voxels_to_volume_end(), 6);
        settle();
        // depth word above the maximum, clamped down; stop after a few slices,
        // then shrink the depth so the positions run past it and wrap home
        load_config(-16'sd40, 3, 3, 1023);
        stream(6 * width_ref * height_ref, 50);
        settle();
        load_config(16'sd9, 3, 3, 3);
        stream(voxels_to_volume_end(), 1);
        settle();

        // threshold rails: nothing inside, then nearly everything inside
        load_config(16'sh8000, 4, 4, 4);
        stream(voxels_to_volume_end(), 3);
        settle();
        load_config(16'sh7FFF, 4, 5, 4);
        stream(voxels_to_volume_end(), 3);
        settle();

        random_sent = 0;
        while (random_sent < RANDOM_VOXELS) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 7);
            h = ($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 7);
            d = ($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 7);
            // a size change inside a volume must not reach behind the first voxel
            if (w * h + w + 1 > voxels_taken) begin
                w = 3;
                h = 3;
                d = 3;
            end
            iso = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                           : int'($urandom_range(400)) - 200;
            load_config(iso[vcc_pkg::DATA_W-1:0], w, h, d);
            n = voxels_to_volume_end();
            if ($urandom_range(3) == 0 && n > 1)
                n = $urandom_range(1, n - 1);  // stop inside the volume
            else if ($urandom_range(1) != 0)
                n += width_ref * height_ref * depth_ref;
            case ($urandom_range(2))
                0: spread = 1;
                1: spread = 6;
                default: spread = 300;
            endcase
            stream(n, spread);
            random_sent += n;
            settle();
        end

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
